// File: hw/rtl/qrndp_pkg.sv
// shared types and constants for the qr numeric data codeword packer
package qrndp_pkg;

	localparam int DATA_CODEWORDS_DEF = 34;
	localparam int COUNT_BITS         = 10;
	localparam int HEADER_BITS        = 4 + COUNT_BITS;
	localparam int ACC_BITS           = 24;
	localparam int ACC_CNT_BITS       = 5;

	localparam logic [3:0]            MODE_NUMERIC = 4'b0001;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 10'h3FF;
	localparam logic [7:0]            PAD_A        = 8'hEC;
	localparam logic [7:0]            PAD_B        = 8'h11;
	localparam logic [3:0]            DIGIT_MAX    = 4'd9;

	// bit lengths of one packed group
	localparam logic [3:0] LEN_NONE  = 4'd0;
	localparam logic [3:0] LEN_ONE   = 4'd4;
	localparam logic [3:0] LEN_TWO   = 4'd7;
	localparam logic [3:0] LEN_THREE = 4'd10;

	// controller to datapath
	typedef struct packed {
		logic take;     // digit item accepted this cycle
		logic drain;    // flush the bit accumulator into the store
		logic advance;  // current codeword item taken
		logic clear;    // message done, back to reset values
	} qrndp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic acc_empty;
		logic emit_last;
	} qrndp_stat_t;

endpackage

// File: hw/rtl/qrndp_ram.sv
// generic single write port ram with registered read
module qrndp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 34
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/qrndp_ctrl.sv
// controller state machine: collect digits, drain accumulator, emit codewords
module qrndp_ctrl import qrndp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	input  qrndp_stat_t stat,
	output qrndp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (in_valid && last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (stat.acc_empty) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_ready && stat.emit_last) begin
						state_q <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_COLLECT);
	assign out_valid   = (state_q == ST_EMIT);
	assign cmd.take    = in_valid && in_ready;
	assign cmd.drain   = (state_q == ST_DRAIN);
	assign cmd.advance = out_valid && out_ready;
	assign cmd.clear   = out_valid && out_ready && stat.emit_last;

endmodule

// File: hw/rtl/qrndp_datapath.sv
// datapath: digit grouping, bit accumulator, codeword store and output formatting
module qrndp_datapath import qrndp_pkg::*; #(
	parameter int DATA_CODEWORDS = DATA_CODEWORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qrndp_cmd_t  cmd,
	output qrndp_stat_t stat,
	input  logic [3:0]  digit,
	input  logic        last,
	output logic [7:0]  codeword,
	output logic        last_codeword,
	output logic        overflow
);

	localparam int CAP  = DATA_CODEWORDS * 8;
	localparam int BPW  = $clog2(CAP + 1);
	localparam int SW   = BPW + 1;
	localparam int IDXW = $clog2(DATA_CODEWORDS);

	localparam logic [SW-1:0]   CAP_S      = SW'(CAP);
	localparam logic [BPW-1:0]  BP_START   = BPW'(HEADER_BITS);
	localparam logic [IDXW-1:0] IDX_LAST   = IDXW'(DATA_CODEWORDS - 1);
	// first store byte holds the low header bits, filled in on output
	localparam logic [IDXW-1:0] WR_START   = IDXW'(HEADER_BITS / 8);
	localparam logic [ACC_CNT_BITS-1:0] ACC_START = ACC_CNT_BITS'(HEADER_BITS % 8);

	logic [BPW-1:0]          bp_q;
	logic [COUNT_BITS-1:0]   cnt_q;
	logic [9:0]              gv_q;
	logic [1:0]              fill_q;
	logic                    drop_q;
	logic [ACC_BITS-1:0]     acc_q;
	logic [ACC_CNT_BITS-1:0] acc_cnt_q;
	logic [IDXW-1:0]         wr_idx_q;
	logic [IDXW-1:0]         emit_idx_q;

	logic [3:0]              d_sat;
	logic [1:0]              fill_inc;
	logic [3:0]              need;
	logic                    fits;
	logic                    ok;
	logic [9:0]              gv_mul;
	logic [1:0]              fill_after;
	logic [9:0]              gv_after;
	logic [3:0]              app_len;
	logic [9:0]              app_left;
	logic                    group_done;
	logic                    drain_now;
	logic [ACC_BITS-1:0]     acc_sh;
	logic [ACC_CNT_BITS-1:0] cnt_sh;
	logic [ACC_BITS-1:0]     acc_n;
	logic [ACC_CNT_BITS-1:0] cnt_n;
	logic [7:0]              rd_data;
	logic                    rd_en;
	logic [IDXW-1:0]         rd_addr;

	logic [SW-1:0]           bp_end4;
	logic [SW-1:0]           end_bits;
	logic [SW-1:0]           nb_bytes;
	logic [SW-1:0]           wr_bytes;
	logic [SW-1:0]           b_ext;

	// digit grouping and capacity check
	always_comb begin
		d_sat    = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
		fill_inc = fill_q + 2'd1;
		case (fill_q)
			2'd0:    need = LEN_ONE;
			2'd1:    need = LEN_TWO;
			default: need = LEN_THREE;
		endcase
		fits = (cnt_q != COUNT_MAX) && (({1'b0, bp_q} + SW'(need)) <= CAP_S);
		ok   = cmd.take && fits;
		gv_mul = 10'((14'(gv_q) << 3) + (14'(gv_q) << 1) + 14'(d_sat));
		fill_after = ok ? fill_inc : fill_q;
		gv_after   = ok ? gv_mul : gv_q;
		group_done = ok && (fill_inc == 2'd3);

		app_len  = LEN_NONE;
		app_left = '0;
		if (group_done) begin
			app_len  = LEN_THREE;
			app_left = gv_mul;
		end else if (cmd.take && last) begin
			case (fill_after)
				2'd1: begin
					app_len  = LEN_ONE;
					app_left = {gv_after[3:0], 6'b0};
				end
				2'd2: begin
					app_len  = LEN_TWO;
					app_left = {gv_after[6:0], 3'b0};
				end
				default: begin
					app_len  = LEN_NONE;
					app_left = '0;
				end
			endcase
		end
	end

	// bit accumulator: one byte out per cycle, msb aligned
	always_comb begin
		drain_now = (acc_cnt_q >= ACC_CNT_BITS'(8)) || (cmd.drain && (acc_cnt_q != '0));
		acc_sh    = drain_now ? (acc_q << 8) : acc_q;
		if (!drain_now) begin
			cnt_sh = acc_cnt_q;
		end else if (acc_cnt_q >= ACC_CNT_BITS'(8)) begin
			cnt_sh = acc_cnt_q - ACC_CNT_BITS'(8);
		end else begin
			cnt_sh = '0;
		end
		acc_n = acc_sh | ({app_left, {(ACC_BITS-10){1'b0}}} >> cnt_sh);
		cnt_n = cnt_sh + ACC_CNT_BITS'(app_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q       <= BP_START;
			cnt_q      <= '0;
			gv_q       <= '0;
			fill_q     <= '0;
			drop_q     <= 1'b0;
			acc_q      <= '0;
			acc_cnt_q  <= ACC_START;
			wr_idx_q   <= WR_START;
			emit_idx_q <= '0;
		end else if (cmd.clear) begin
			bp_q       <= BP_START;
			cnt_q      <= '0;
			gv_q       <= '0;
			fill_q     <= '0;
			drop_q     <= 1'b0;
			acc_q      <= '0;
			acc_cnt_q  <= ACC_START;
			wr_idx_q   <= WR_START;
			emit_idx_q <= '0;
		end else begin
			acc_q     <= acc_n;
			acc_cnt_q <= cnt_n;
			bp_q      <= bp_q + BPW'(app_len);
			if (drain_now) begin
				wr_idx_q <= wr_idx_q + IDXW'(1);
			end
			if (ok) begin
				cnt_q <= cnt_q + COUNT_BITS'(1);
			end
			if (cmd.take && !fits) begin
				drop_q <= 1'b1;
			end
			if (group_done || (cmd.take && last)) begin
				gv_q   <= '0;
				fill_q <= '0;
			end else if (ok) begin
				gv_q   <= gv_mul;
				fill_q <= fill_inc;
			end
			if (cmd.advance && !last_codeword) begin
				emit_idx_q <= emit_idx_q + IDXW'(1);
			end
		end
	end

	// next byte is fetched as the current one is taken
	assign rd_en   = cmd.advance && !last_codeword;
	assign rd_addr = emit_idx_q + IDXW'(1);

	qrndp_ram #(
		.WIDTH (8),
		.DEPTH (DATA_CODEWORDS)
	) u_store (
		.clk   (clk),
		.we    (drain_now),
		.waddr (wr_idx_q),
		.wdata (acc_q[ACC_BITS-1 -: 8]),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// output formatting: header, data bytes, zero terminator bytes, pad bytes
	always_comb begin
		bp_end4  = {1'b0, bp_q} + SW'(4);
		end_bits = (bp_end4 > CAP_S) ? CAP_S : bp_end4;
		nb_bytes = (end_bits + SW'(7)) >> 3;
		wr_bytes = ({1'b0, bp_q} + SW'(7)) >> 3;
		b_ext    = SW'(emit_idx_q);
		if (emit_idx_q == '0) begin
			codeword = {MODE_NUMERIC, cnt_q[COUNT_BITS-1 -: 4]};
		end else if (emit_idx_q == IDXW'(1)) begin
			codeword = {cnt_q[5:0], rd_data[1:0]};
		end else if (b_ext < wr_bytes) begin
			codeword = rd_data;
		end else if (b_ext < nb_bytes) begin
			codeword = '0;
		end else if (b_ext[0] ^ nb_bytes[0]) begin
			codeword = PAD_B;
		end else begin
			codeword = PAD_A;
		end
	end

	assign last_codeword  = (emit_idx_q == IDX_LAST);
	assign overflow       = drop_q;
	assign stat.acc_empty = (acc_cnt_q == '0);
	assign stat.emit_last = last_codeword;

endmodule

// File: hw/rtl/qr_numeric_data_codeword_packer_unit.sv
// top level of the qr numeric-mode data codeword packer
//
// input channel: one decimal digit per item (in_valid/in_ready), with last
// marking the final digit; digits above nine count as nine
// output channel: one data codeword per item (out_valid/out_ready), msb
// first, with last_codeword on the final one and overflow if any digit of
// the message did not fit and was dropped
// digits are taken one per cycle while in_ready is high; groups of three, and a
// shorter tail group, go into a bit accumulator that writes one byte per cycle
// into a codeword store; after the item with last the accumulator drains, then
// DATA_CODEWORDS codewords follow at one per cycle while out_ready stays high
// in_ready is low from the item with last until the final codeword is taken
// a stalled receiver simply holds the current codeword; nothing is lost
// reset (arst_n low) clears all control state and drops any partial message;
// the store needs no clearing since every byte used as output is written first
module qr_numeric_data_codeword_packer_unit import qrndp_pkg::*; #(
	parameter int DATA_CODEWORDS = DATA_CODEWORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] digit,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] codeword,
	output logic       last_codeword,
	output logic       overflow
);

	qrndp_cmd_t  cmd;
	qrndp_stat_t stat;

	// sequencing of collect, drain and emit phases
	qrndp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// packing, codeword store and output formatting
	qrndp_datapath #(
		.DATA_CODEWORDS (DATA_CODEWORDS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.digit         (digit),
		.last          (last),
		.codeword      (codeword),
		.last_codeword (last_codeword),
		.overflow      (overflow)
	);

endmodule

// File: tb/tb_qr_numeric_data_codeword_packer_unit.sv
`timescale 1ns / 1ps
// testbench for the qr numeric data codeword packer: directed and random digit messages
module tb_qr_numeric_data_codeword_packer_unit;
	import qrndp_pkg::*;

	localparam int NCW          = DATA_CODEWORDS_DEF;
	localparam int CAP_BITS     = NCW * 8;
	localparam int RANDOM_ITEMS = 320;
	// the receiver goes quiet for a long stretch once this many codewords are in
	localparam int HOLD_AT      = 9 * NCW + 5;
	localparam int HOLD_CYCLES  = 300;
	localparam int DIR_ROWS     = 23;

	// one codeword item as it should leave the block
	typedef struct packed {
		logic [7:0] cw;
		logic       lastcw;
		logic       ovf;
	} word_t;

	// one row of the directed table; known rows carry the first three codewords
	// and the overflow flag typed in, the rest of such a frame is plain padding
	typedef struct packed {
		logic [3:0] d;
		logic       l;
		logic       known;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       ovf;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] digit = 4'd0;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] codeword;
	logic       last_codeword;
	logic       overflow;

	// directed messages: single digits right after reset and at the extremes
	// (values above nine count as nine), then pairs, triples and mixed tails
	row_t dir_rows [DIR_ROWS] = '{
		'{4'd0,  1'b1, 1'b1, 8'h10, 8'h04, 8'h00, 1'b0},
		'{4'd9,  1'b1, 1'b1, 8'h10, 8'h06, 8'h40, 1'b0},
		'{4'd15, 1'b1, 1'b1, 8'h10, 8'h06, 8'h40, 1'b0},
		'{4'd1,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd2,  1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd1,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd2,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd3,  1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd9,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd8,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd7,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd6,  1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd15, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd14, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd13, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd12, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd11, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd10, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd5,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd0,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd9,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd3,  1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{4'd8,  1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0}
	};

	// packer state kept on the testbench side
	logic [7:0]  cw_image [NCW];
	int unsigned bit_pos;
	int unsigned digits_taken;
	int unsigned grp_val;
	int unsigned grp_len;
	logic        lost_digits;

	// the codewords of the message just flushed
	logic [7:0]  frame [NCW];
	logic        frame_ovf;

	word_t pending_words [$];
	word_t exp_word;
	int    errors = 0;
	int    sent = 0;
	int    taken = 0;

	qr_numeric_data_codeword_packer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.digit         (digit),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.codeword      (codeword),
		.last_codeword (last_codeword),
		.overflow      (overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// msb-first bit writer into the codeword image, bits past capacity fall away
	function automatic void write_field(int unsigned p0, int unsigned val, int unsigned n);
		int unsigned p;
		for (int unsigned i = 0; i < n; i++) begin
			p = p0 + i;
			if (p < CAP_BITS)
				cw_image[p >> 3][7 - (p & 7)] = 1'((val >> (n - 1 - i)) & 1);
		end
	endfunction

	function automatic void restart_message();
		bit_pos      = HEADER_BITS;
		digits_taken = 0;
		grp_val      = 0;
		grp_len      = 0;
		lost_digits  = 1'b0;
	endfunction

	// takes one digit item; on last it builds the whole codeword frame
	function automatic void pack_digit(logic [3:0] raw, logic fin);
		int unsigned d;
		int unsigned nf;
		int unsigned need;
		int unsigned stop;
		int unsigned k;
		d    = (raw > DIGIT_MAX) ? DIGIT_MAX : raw;
		nf   = grp_len + 1;
		need = (nf == 1) ? LEN_ONE : (nf == 2) ? LEN_TWO : LEN_THREE;
		// a digit fits only if its whole group still fits and the count has room
		if (digits_taken < COUNT_MAX && bit_pos + need <= CAP_BITS) begin
			grp_val = grp_val * 10 + d;
			grp_len = nf;
			digits_taken++;
			if (grp_len == 3) begin
				write_field(bit_pos, grp_val, LEN_THREE);
				bit_pos += LEN_THREE;
				grp_val = 0;
				grp_len = 0;
			end
		end else begin
			lost_digits = 1'b1;
		end
		if (!fin)
			return;
		// short tail group
		if (grp_len == 1) begin
			write_field(bit_pos, grp_val, LEN_ONE);
			bit_pos += LEN_ONE;
		end else if (grp_len == 2) begin
			write_field(bit_pos, grp_val, LEN_TWO);
			bit_pos += LEN_TWO;
		end
		write_field(0, MODE_NUMERIC, 4);
		write_field(4, digits_taken & COUNT_MAX, COUNT_BITS);
		// terminator clipped at capacity, then zeros up to the byte boundary
		stop = bit_pos + 4;
		if (stop > CAP_BITS)
			stop = CAP_BITS;
		stop = (stop + 7) & ~32'd7;
		for (int unsigned p = bit_pos; p < stop; p++)
			write_field(p, 0, 1);
		k = 0;
		for (int unsigned b = stop >> 3; b < NCW; b++) begin
			cw_image[b] = k[0] ? PAD_B : PAD_A;
			k++;
		end
		for (int b = 0; b < NCW; b++)
			frame[b] = cw_image[b];
		frame_ovf = lost_digits;
		restart_message();
	endfunction

	function automatic void push_frame();
		for (int b = 0; b < NCW; b++)
			pending_words.push_back('{frame[b], b == NCW - 1, frame_ovf});
	endfunction

	function automatic int draw_gap(bit quiet);
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	// offers one digit item after an idle gap, waits for the handshake, then
	// runs it through the packer model
	task automatic offer(logic [3:0] d, logic l, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		digit    <= d;
		last     <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		pack_digit(d, l);
	endtask

	// a whole message; fill < 0 gives random digits, now and then above nine
	task automatic send_message(int len, int fill);
		bit         quiet;
		logic [3:0] d;
		quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if (fill >= 0)
				d = 4'(fill);
			else if ($urandom_range(0, 7) == 0)
				d = 4'($urandom_range(10, 15));
			else
				d = 4'($urandom_range(0, 9));
			offer(d, i == len - 1, draw_gap(quiet));
		end
		push_frame();
	endtask

	// stimulus
	initial begin
		int r;
		int start_count;
		for (int b = 0; b < NCW; b++)
			cw_image[b] = 8'h00;
		restart_message();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			offer(dir_rows[i].d, dir_rows[i].l, draw_gap(1'b0));
			if (dir_rows[i].l) begin
				if (dir_rows[i].known) begin
					frame[0] = dir_rows[i].b0;
					frame[1] = dir_rows[i].b1;
					frame[2] = dir_rows[i].b2;
					for (int b = 3; b < NCW; b++)
						frame[b] = ((b - 3) & 1) ? PAD_B : PAD_A;
					frame_ovf = dir_rows[i].ovf;
				end
				push_frame();
			end
		end
		// too many digits, the last three dropped but still flushing
		send_message(80, 9);
		// longest message that fits exactly
		send_message(77, -1);

		// random messages, mostly short, some near and past capacity
		start_count = sent;
		while (sent < start_count + RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				send_message($urandom_range(1, 12), -1);
			else if (r < 9)
				send_message($urandom_range(13, 60), -1);
			else
				send_message($urandom_range(70, 90), -1);
		end
		in_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver: random stalls, bursts with none, and one long hold so the
	// block backs up and drops in_ready
	initial begin
		int  stall;
		bit  quiet;
		quiet = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_gap(quiet);
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
			if (taken % 37 == 0)
				quiet = ($urandom_range(0, 3) == 0);
		end
	end

	// codeword checker against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected codeword, actual %02h", $time, codeword);
				errors++;
			end else begin
				exp_word = pending_words.pop_front();
				if (codeword !== exp_word.cw) begin
					$display("%0t: codeword expected %02h actual %02h",
						$time, exp_word.cw, codeword);
					errors++;
				end
				if (last_codeword !== exp_word.lastcw) begin
					$display("%0t: last_codeword expected %0b actual %0b",
						$time, exp_word.lastcw, last_codeword);
					errors++;
				end
				if (overflow !== exp_word.ovf) begin
					$display("%0t: overflow expected %0b actual %0b",
						$time, exp_word.ovf, overflow);
					errors++;
				end
			end
		end
	end

	// hang guard
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/qrndp_pkg.sv
hw/rtl/qrndp_ram.sv
hw/rtl/qrndp_ctrl.sv
hw/rtl/qrndp_datapath.sv
hw/rtl/qr_numeric_data_codeword_packer_unit.sv
tb/tb_qr_numeric_data_codeword_packer_unit.sv
